// ===== src/ccdf_pkg.sv =====
// ----------------------------------------------------------------------------
// ccdf_pkg
// Shared constants and types for the decimal fixed-point CORDIC cosine.
// ----------------------------------------------------------------------------
package ccdf_pkg;

  // Field widths
  localparam int ANGLE_W = 31;
  localparam int OUT_W   = 28;
  // Width of the CORDIC datapath (x, y, z and the reduced angle)
  localparam int CW      = 30;
  // Largest number of rotation steps with a table entry
  localparam int MAX_STEPS = 10;

  // Decimal fixed-point constants, scale 1e8
  localparam int PI_FX        = 314159265;
  localparam int HALF_PI_FX   = 157079632;
  localparam int X_START      = 60725293;
  localparam int QUARTER_TURN = 78539816;

  localparam int OUT_MAX = 134217727;
  localparam int OUT_MIN = -134217728;

  // atan(2^-i) * 1e8
  localparam int ATAN_TABLE [MAX_STEPS] = '{
    78539816, 46364760, 24497866, 12435499, 6241880,
    3123983, 1562372, 781234, 390623, 195312
  };

  // Register map
  localparam logic REG_ANGLE_TABLE_MODE = 1'b0;

  // angle_table_mode codes
  localparam logic MODE_HALVING = 1'b0;
  localparam logic MODE_ATAN    = 1'b1;

  // One beat travelling down the rotation chain
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] theta;
    logic                 negate;
  } ccdf_beat_t;

endpackage

// ===== src/ccdf_reduce.sv =====
// ----------------------------------------------------------------------------
// ccdf_reduce
// Three-stage range reduction into [-pi/2, pi/2] plus result sign.
// ----------------------------------------------------------------------------
module ccdf_reduce (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  output logic                                     ready_o,
  input  logic signed [ccdf_pkg::ANGLE_W-1:0]      angle_i,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output ccdf_pkg::ccdf_beat_t                     beat_o
);

  localparam int CW = ccdf_pkg::CW;
  localparam int MW = 29;  // remainder in [0, pi)

  // a >= k*pi - pi/2, k = -2 .. 3
  localparam int THR [6] = '{
    -785398162, -471238897, -157079632, 157079633, 471238898, 785398163
  };

  // ---- stage A: quotient floor((a + pi/2) / pi) by threshold compare
  logic                                 va_q;
  logic signed [ccdf_pkg::ANGLE_W-1:0]  a_a_q;
  logic [2:0]                           q_a_q;
  logic                                 red_a_q;
  logic                                 tneg_a_q;
  logic                                 rdy_a, rdy_b, rdy_c;
  logic [2:0]                           cnt;
  logic signed [31:0]                   a_ext;

  always_comb begin
    a_ext = 32'(angle_i);
    cnt   = '0;
    for (int k = 0; k < 6; k++) begin
      cnt = cnt + 3'(a_ext >= 32'(THR[k]));
    end
  end

  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (rdy_a) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      a_a_q    <= angle_i;
      q_a_q    <= cnt - 3'd3;
      red_a_q  <= (a_ext > 32'(ccdf_pkg::HALF_PI_FX)) ||
                  (a_ext < -32'(ccdf_pkg::HALF_PI_FX));
      tneg_a_q <= (a_ext < -32'(ccdf_pkg::HALF_PI_FX));
    end
  end

  // ---- stage B: floor remainder m = a + pi/2 - q*pi
  logic               vb_q;
  logic signed [31:0] k_off;
  logic signed [31:0] m_full;
  logic [MW-1:0]      m_b_q;
  logic signed [MW-1:0] a_b_q;
  logic               red_b_q;
  logic               tneg_b_q;
  logic               neg_b_q;

  // q*pi - pi/2
  always_comb begin
    case (q_a_q)
      3'b101:  k_off = -32'sd1099557427;
      3'b110:  k_off = -32'sd785398162;
      3'b111:  k_off = -32'sd471238897;
      3'b000:  k_off = -32'sd157079632;
      3'b001:  k_off = 32'sd157079633;
      3'b010:  k_off = 32'sd471238898;
      3'b011:  k_off = 32'sd785398163;
      default: k_off = -32'sd157079632;
    endcase
    m_full = 32'(a_a_q) - k_off;
  end

  assign rdy_b = !vb_q || rdy_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (rdy_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      m_b_q    <= m_full[MW-1:0];
      a_b_q    <= a_a_q[MW-1:0];
      red_b_q  <= red_a_q;
      tneg_b_q <= tneg_a_q;
      neg_b_q  <= q_a_q[0];
    end
  end

  // ---- stage C: folded remainder - pi/2, or the angle itself if |a| <= pi/2
  logic                 vc_q;
  logic [MW-1:0]        abs_rem;
  logic signed [CW-1:0] theta;
  ccdf_pkg::ccdf_beat_t beat_q;

  always_comb begin
    if (tneg_b_q && (m_b_q != '0)) begin
      abs_rem = MW'(ccdf_pkg::PI_FX) - m_b_q;
    end else begin
      abs_rem = m_b_q;
    end
    if (red_b_q) begin
      theta = CW'({1'b0, abs_rem}) - CW'(ccdf_pkg::HALF_PI_FX);
    end else begin
      theta = CW'(a_b_q);
    end
  end

  assign rdy_c = !vc_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (rdy_c) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) begin
      beat_q.x      <= CW'(ccdf_pkg::X_START);
      beat_q.y      <= '0;
      beat_q.z      <= '0;
      beat_q.theta  <= theta;
      beat_q.negate <= neg_b_q;
    end
  end

  assign valid_o = vc_q;
  assign beat_o  = beat_q;

endmodule

// ===== src/ccdf_cell.sv =====
// ----------------------------------------------------------------------------
// ccdf_cell
// One CORDIC rotation step with its own pipeline register.
// ----------------------------------------------------------------------------
module ccdf_cell #(
  parameter int STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 mode_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  ccdf_pkg::ccdf_beat_t beat_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output ccdf_pkg::ccdf_beat_t beat_o
);

  localparam int CW = ccdf_pkg::CW;
  localparam logic signed [CW-1:0] A_EXACT = CW'(ccdf_pkg::ATAN_TABLE[STAGE]);
  localparam logic signed [CW-1:0] A_HALF  = CW'(ccdf_pkg::QUARTER_TURN >> STAGE);

  logic signed [CW-1:0] x, y, z, th, ang;
  logic signed [CW-1:0] sx, sy, snx, sny;
  logic                 up;
  logic                 valid_q;
  ccdf_pkg::ccdf_beat_t beat_d, beat_q;

  always_comb begin
    x   = beat_i.x;
    y   = beat_i.y;
    z   = beat_i.z;
    th  = beat_i.theta;
    up  = z > th;
    ang = (mode_i == ccdf_pkg::MODE_ATAN) ? A_EXACT : A_HALF;
    // floor shifts of +/- operands
    sx  = x >>> STAGE;
    sy  = y >>> STAGE;
    snx = (-x) >>> STAGE;
    sny = (-y) >>> STAGE;
    beat_d        = beat_i;
    beat_d.x      = up ? x - sy : x - sny;
    beat_d.y      = up ? y + sx : y + snx;
    beat_d.z      = up ? z - ang : z + ang;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== src/cordic_cosine_decimal_fixed.sv =====
// ----------------------------------------------------------------------------
// cordic_cosine_decimal_fixed
// Cosine of an angle in radians, both scaled by 1e8, via a CORDIC chain.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid_i / in_ready_o carries angle_i (31-bit signed).
//    Output channel out_valid_o / out_ready_i carries cosine_o (28-bit
//    signed). A beat moves on a clock edge where valid and ready are high.
//  - From input beat to output valid a beat passes three reduction stages,
//    one register per rotation cell (ten steps by default) and one output
//    register.
//  - Throughput is one beat per cycle; the input only stalls once every stage
//    is full. Every stage is a register with its own valid bit, so bubbles
//    are squeezed out and a new angle is taken while a finished cosine waits.
//  - A stalled receiver holds the output register; stages behind it keep
//    filling until the chain is full.
//  - Reset empties the pipeline and sets angle_table_mode to 1 (exact
//    arctangent table). The register is at APB address 0 and may only be
//    rewritten while the pipeline is empty.
// ----------------------------------------------------------------------------
module cordic_cosine_decimal_fixed #(
  parameter int ITERATIONS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // angle channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [ccdf_pkg::ANGLE_W-1:0] angle_i,
  // cosine channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ccdf_pkg::OUT_W-1:0]   cosine_o,
  // APB configuration port
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [2:0]                          paddr_i,
  input  logic [31:0]                         pwdata_i,
  output logic [31:0]                         prdata_o,
  output logic                                pready_o
);

  localparam int CW = ccdf_pkg::CW;
  localparam int OW = ccdf_pkg::OUT_W;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic mode_q;
  logic cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ccdf_pkg::MODE_ATAN;
    end else if (cfg_wr && (paddr_i[2] == ccdf_pkg::REG_ANGLE_TABLE_MODE)) begin
      mode_q <= pwdata_i[0];
    end
  end

  assign prdata_o = (paddr_i[2] == ccdf_pkg::REG_ANGLE_TABLE_MODE) ?
                    {31'd0, mode_q} : 32'd0;

  // --------------------------------------------------------------------------
  // Range reduction
  // --------------------------------------------------------------------------
  logic                 chain_valid [ITERATIONS+1];
  logic                 chain_ready [ITERATIONS+1];
  ccdf_pkg::ccdf_beat_t chain_beat  [ITERATIONS+1];

  ccdf_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .angle_i (angle_i),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .beat_o  (chain_beat[0])
  );

  // --------------------------------------------------------------------------
  // Rotation chain: one cell per step, each registered
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
    ccdf_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .mode_i  (mode_q),
      .valid_i (chain_valid[g]),
      .ready_o (chain_ready[g]),
      .beat_i  (chain_beat[g]),
      .valid_o (chain_valid[g+1]),
      .ready_i (chain_ready[g+1]),
      .beat_o  (chain_beat[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Sign and saturation into the output register
  // --------------------------------------------------------------------------
  logic signed [CW:0]   x_ext, x_sgn;
  logic signed [OW-1:0] cos_d, cos_q;
  logic                 out_valid_q;

  always_comb begin
    x_ext = (CW+1)'(chain_beat[ITERATIONS].x);
    x_sgn = chain_beat[ITERATIONS].negate ? -x_ext : x_ext;
    if (x_sgn > (CW+1)'(ccdf_pkg::OUT_MAX)) begin
      cos_d = OW'(ccdf_pkg::OUT_MAX);
    end else if (x_sgn < (CW+1)'(ccdf_pkg::OUT_MIN)) begin
      cos_d = OW'(ccdf_pkg::OUT_MIN);
    end else begin
      cos_d = x_sgn[OW-1:0];
    end
  end

  assign chain_ready[ITERATIONS] = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (chain_ready[ITERATIONS]) begin
      out_valid_q <= chain_valid[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_ready[ITERATIONS] && chain_valid[ITERATIONS]) begin
      cos_q <= cos_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cosine_o    = cos_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Input only backs off when the whole chain is full behind a stalled sink.
  a_stall_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled with room in the pipeline");

  // Reduced angle always lands in [-pi/2, pi/2].
  a_theta_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_valid[0] |-> ((chain_beat[0].theta <= CW'(ccdf_pkg::HALF_PI_FX)) &&
                        (chain_beat[0].theta >= -CW'(ccdf_pkg::HALF_PI_FX))))
    else $error("reduced angle out of range");

  // CORDIC gain keeps the result near unity: saturation never needed.
  a_cos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((cosine_o <= OW'(110000000)) && (cosine_o >= -OW'(110000000))))
    else $error("cosine magnitude beyond CORDIC gain bound");

endmodule
